// File: rtl/arctan_series_evaluator_core_defines.svh
// Assertion macros shared by the arctan series evaluator RTL.
`ifndef ARCTAN_SERIES_EVALUATOR_CORE_DEFINES_SVH
`define ARCTAN_SERIES_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/atse_pkg.sv
package atse_pkg;

  // Field widths of the argument, the results and the term count register.
  localparam int unsigned XW      = 32;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned FRAC_W  = 30;
  localparam int unsigned TC_W    = 6;
  localparam int unsigned ACC_W   = 34;

  // Default for the term limit and reset value of the term count.
  localparam int unsigned MAX_TERMS_DEF = 32;
  localparam logic [TC_W-1:0] TC_RESET  = 6'd8;

  // One in Q1.30.
  localparam logic [MAG_W-1:0] ONE_Q30 = 31'h4000_0000;

  // Cycle count of one restoring division, one quotient bit per cycle.
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd30;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// File: rtl/atse_in_if.sv
// Argument channel.
interface atse_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [atse_pkg::XW-1:0]  x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

// File: rtl/atse_out_if.sv
// Result channel.
interface atse_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [atse_pkg::XW-1:0]    approximation;
  logic        [atse_pkg::MAG_W-1:0] remainder_bound;

  modport source (output valid, output approximation, output remainder_bound, input ready);
  modport sink (input valid, input approximation, input remainder_bound, output ready);
endinterface

// File: rtl/arctan_series_evaluator_core.sv
// Sequence: an accepted argument passes S_SQ, then S_LOAD and S_DIV for each of the n terms
// and for the bound, then S_OUT, where n = min(term_count, MAX_TERMS).
// A new argument is taken only once the previous result is in the output register,
// later if an older result still waits there.
// Each term and the bound take one multiplier step and a bit-serial division.
// Reset (rst_n, synchronous, active low) clears the sequencer, the output valid flag, term_count=8.
`include "arctan_series_evaluator_core_defines.svh"

module arctan_series_evaluator_core #(
  parameter int unsigned MAX_TERMS = atse_pkg::MAX_TERMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  atse_in_if.sink                     in_ch,
  atse_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [atse_pkg::TC_W-1:0]   cfg_wdata
);

  localparam int unsigned K_W   = $clog2(MAX_TERMS + 1);
  localparam int unsigned DIV_W = K_W + 1;
  localparam int unsigned MW    = atse_pkg::MAG_W;

  atse_pkg::state_t state_r, state_nxt;

  logic [atse_pkg::TC_W-1:0]       cfg_r;
  logic                            out_valid_r, out_valid_nxt;
  logic                            neg_r, neg_nxt;
  logic [MW-1:0]                   mag_r, mag_nxt;
  logic [MW-1:0]                   s2_r, s2_nxt;
  logic [MW-1:0]                   p_r, p_nxt;
  logic [K_W-1:0]                  k_r, k_nxt;
  logic [K_W-1:0]                  n_r, n_nxt;
  logic signed [atse_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [MW-1:0]                   quo_r, quo_nxt;
  logic [DIV_W-1:0]                rem_r, rem_nxt;
  logic [atse_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            last_r, last_nxt;
  logic signed [atse_pkg::XW-1:0]  approx_r, approx_nxt;
  logic [MW-1:0]                   bound_r, bound_nxt;

  logic [atse_pkg::XW-1:0]         abs_x;
  logic [MW-1:0]                   mul_a, mul_b, mul_q;
  logic [2*MW-1:0]                 prod;
  logic [DIV_W-1:0]                divisor;
  logic [DIV_W:0]                  trial;
  logic                            qbit;
  logic signed [atse_pkg::ACC_W-1:0] term_s, res_s;

  assign in_ch.ready           = (state_r == atse_pkg::S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.approximation  = approx_r;
  assign out_ch.remainder_bound = bound_r;

  // Magnitude of the argument; the clamp to one is applied when it is loaded in S_IDLE.
  assign abs_x = in_ch.x_value[atse_pkg::XW-1] ? (~in_ch.x_value + 1'b1) : in_ch.x_value;

  // Shared multiplier: x squared first, then each next odd power.
  assign mul_a = (state_r == atse_pkg::S_SQ) ? mag_r : p_r;
  assign mul_b = (state_r == atse_pkg::S_SQ) ? mag_r : s2_r;
  assign prod  = (2*MW)'(mul_a) * (2*MW)'(mul_b);
  assign mul_q = prod[atse_pkg::FRAC_W +: MW];

  // One restoring division step by the odd divisor 2k+1.
  assign divisor = {k_r, 1'b1};
  assign trial   = {rem_r, quo_r[MW-1]} - {1'b0, divisor};
  assign qbit    = ~trial[DIV_W];
  assign term_s  = $signed({{(atse_pkg::ACC_W-MW){1'b0}}, quo_nxt});
  assign res_s   = neg_r ? -acc_r : acc_r;

  // Sequencer next state and datapath.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    s2_nxt        = s2_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    approx_nxt    = approx_r;
    bound_nxt     = bound_r;
    case (state_r)
      atse_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          neg_nxt = in_ch.x_value[atse_pkg::XW-1];
          mag_nxt = (abs_x > atse_pkg::XW'(atse_pkg::ONE_Q30)) ? atse_pkg::ONE_Q30
                                                               : abs_x[MW-1:0];
          p_nxt   = mag_nxt;
          n_nxt   = (32'(cfg_r) > 32'(MAX_TERMS)) ? K_W'(MAX_TERMS) : K_W'(cfg_r);
          k_nxt   = '0;
          acc_nxt = '0;
          state_nxt = atse_pkg::S_SQ;
        end
      end
      atse_pkg::S_SQ: begin
        s2_nxt    = mul_q;
        state_nxt = atse_pkg::S_LOAD;
      end
      atse_pkg::S_LOAD: begin
        // Start dividing p(k); unless k equals n, the next power is formed in the same cycle.
        quo_nxt  = p_r;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        last_nxt = (k_r == n_r);
        if (k_r != n_r) begin
          p_nxt = mul_q;
        end
        state_nxt = atse_pkg::S_DIV;
      end
      atse_pkg::S_DIV: begin
        quo_nxt = {quo_r[MW-2:0], qbit};
        rem_nxt = qbit ? trial[DIV_W-1:0] : {rem_r[DIV_W-2:0], quo_r[MW-1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == atse_pkg::DIV_LAST) begin
          if (last_r) begin
            state_nxt = atse_pkg::S_OUT;
          end else begin
            acc_nxt   = k_r[0] ? (acc_r - term_s) : (acc_r + term_s);
            k_nxt     = k_r + 1'b1;
            state_nxt = atse_pkg::S_LOAD;
          end
        end
      end
      atse_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          bound_nxt     = quo_r;
          if (res_s > atse_pkg::ACC_W'(32'sh7FFF_FFFF)) begin
            approx_nxt = 32'sh7FFF_FFFF;
          end else if (res_s < -(atse_pkg::ACC_W'(33'sh0_8000_0000))) begin
            approx_nxt = 32'sh8000_0000;
          end else begin
            approx_nxt = res_s[atse_pkg::XW-1:0];
          end
          state_nxt = atse_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = atse_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atse_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= atse_pkg::TC_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    s2_r     <= s2_nxt;
    p_r      <= p_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
    approx_r <= approx_nxt;
    bound_r  <= bound_nxt;
  end

  // Checks on the sequencer and the divider.
  `ATSE_ASSERT_SAME(a_rem_below_divisor, clk, rst_n, state_r == atse_pkg::S_DIV, rem_r < divisor, "partial remainder not below divisor")
  `ATSE_ASSERT_SAME(a_k_within_n, clk, rst_n, state_r == atse_pkg::S_LOAD || state_r == atse_pkg::S_DIV, k_r <= n_r, "term index beyond term count")
  `ATSE_ASSERT_NEXT(a_div_ends, clk, rst_n, state_r == atse_pkg::S_DIV && cnt_r == atse_pkg::DIV_LAST, state_r == atse_pkg::S_LOAD || state_r == atse_pkg::S_OUT, "division did not end after its last step")
  `ATSE_ASSERT_SAME(a_result_from_out, clk, rst_n, $rose(out_valid_r), $past(state_r) == atse_pkg::S_OUT, "result raised outside the output step")

endmodule

// File: bench/tb_arctan_series_evaluator_core.sv
`timescale 1ns / 100ps

module tb_arctan_series_evaluator_core;

  localparam int unsigned TERM_LIMIT = atse_pkg::MAX_TERMS_DEF;
  localparam int unsigned LONG_HOLD  = 600;

  // Expected result of one argument.
  typedef struct packed {
    logic signed [atse_pkg::XW-1:0] approximation;
    logic [atse_pkg::MAG_W-1:0]     remainder_bound;
  } arctan_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [atse_pkg::TC_W-1:0] cfg_wdata;

  atse_in_if  arg_bus ();
  atse_out_if res_bus ();

  // Local copy of the term count register.
  logic [atse_pkg::TC_W-1:0] term_count_copy;

  arctan_result_t pending_results[$];
  int unsigned    mismatch_count;
  bit             src_idle_on;
  bit             snk_idle_on;
  bit             hold_request;

  arctan_series_evaluator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (arg_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Series sum and remainder bound of one argument at a given term count.
  function automatic arctan_result_t predict_arctan(input logic [atse_pkg::XW-1:0] raw,
                                                    input logic [atse_pkg::TC_W-1:0] count);
    arctan_result_t   r;
    logic [63:0]      mag;
    logic [63:0]      sq;
    logic [63:0]      pw;
    logic [63:0]      quot;
    logic signed [63:0] acc;
    logic signed [63:0] sum;
    int unsigned      n;
    bit               neg;
    neg = raw[atse_pkg::XW-1];
    mag = neg ? ((64'd1 << 32) - {32'd0, raw}) : {32'd0, raw};
    if (mag > {33'd0, atse_pkg::ONE_Q30}) begin
      mag = {33'd0, atse_pkg::ONE_Q30};
    end
    n = (count > TERM_LIMIT) ? TERM_LIMIT : count;
    sq = (mag * mag) >> atse_pkg::FRAC_W;
    pw = mag;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      quot = pw / 64'(2 * k + 1);
      if (k % 2 == 1) begin
        acc = acc - $signed(quot);
      end else begin
        acc = acc + $signed(quot);
      end
      pw = (pw * sq) >> atse_pkg::FRAC_W;
    end
    quot = pw / 64'(2 * n + 1);
    sum = neg ? -acc : acc;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
    end
    r.approximation   = sum[atse_pkg::XW-1:0];
    r.remainder_bound = quot[atse_pkg::MAG_W-1:0];
    return r;
  endfunction

  // Random argument: mostly in range, sometimes any 32-bit pattern.
  function automatic logic [atse_pkg::XW-1:0] random_arg();
    logic [atse_pkg::XW-1:0] mag;
    int unsigned   sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      return $urandom();
    end
    if (sel == 2) begin
      mag = 32'h4000_0000 - $urandom_range(0, 16);
    end else if (sel == 3) begin
      mag = $urandom_range(0, 32'h0001_0000);
    end else begin
      mag = $urandom_range(0, 32'h4000_0000);
    end
    return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
  endfunction

  // Offer one argument and record its expected result on acceptance.
  task automatic send_arg(input logic [atse_pkg::XW-1:0] x);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      arg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    arg_bus.valid   <= 1'b1;
    arg_bus.x_value <= x;
    do @(posedge clk); while (!arg_bus.ready);
    pending_results.push_back(predict_arctan(x, term_count_copy));
  endtask

  // Drop valid after the last transaction of a phase and wait for all results.
  task automatic drain_results();
    arg_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_term_count(input logic [atse_pkg::TC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    term_count_copy = value;
    @(posedge clk);
  endtask

  // Extremes of the argument under the reset term count.
  task automatic test_reset_count_extremes();
    send_arg(32'h0000_0000);
    send_arg(32'h4000_0000);
    send_arg(32'hC000_0000);
    send_arg(32'h3FFF_FFFF);
    send_arg(32'hC000_0001);
    send_arg(32'h0000_0001);
    send_arg(32'hFFFF_FFFF);
    send_arg(32'h2000_0000);
    // Arguments beyond one saturate to one with the sign kept.
    send_arg(32'h4000_0001);
    send_arg(32'hBFFF_FFFF);
    send_arg(32'h7FFF_FFFF);
    send_arg(32'h8000_0000);
    drain_results();
  endtask

  // With no terms the sum is zero and the bound is the magnitude.
  task automatic test_zero_terms();
    write_term_count(6'd0);
    send_arg(32'h4000_0000);
    send_arg(32'hA5A5_5A5A);
    send_arg(32'h1234_5678);
    drain_results();
  endtask

  // Counts above the term limit behave as the limit.
  task automatic test_count_saturation();
    write_term_count(6'd63);
    send_arg(32'h4000_0000);
    send_arg(32'hD000_0000);
    drain_results();
    write_term_count(6'(TERM_LIMIT + 1));
    send_arg(32'h3000_0000);
    drain_results();
    write_term_count(6'(TERM_LIMIT));
    send_arg(32'hC000_0000);
    send_arg(32'h2AAA_AAAA);
    drain_results();
    write_term_count(6'd1);
    send_arg(32'h4000_0000);
    send_arg(32'h8000_0000);
    drain_results();
  endtask

  // Random arguments over several term counts, extremes among them.
  task automatic test_random_phases();
    logic [atse_pkg::TC_W-1:0] count;
    int unsigned     items;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       count = 6'd0;
        1:       count = 6'd63;
        2:       count = 6'(TERM_LIMIT);
        3:       count = 6'($urandom_range(TERM_LIMIT + 1, 63));
        default: count = 6'($urandom_range(1, 12));
      endcase
      write_term_count(count);
      items = (count >= 16) ? 15 : 60;
      for (int i = 0; i < items; i++) begin
        send_arg(random_arg());
      end
      drain_results();
    end
  endtask

  // Receiver holds off for a long stretch so the block stalls its input.
  task automatic test_backpressure();
    write_term_count(6'd2);
    src_idle_on  = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_arg(random_arg());
    end
    drain_results();
    src_idle_on = 1'b1;
  endtask

  // Final stretch without idling on either side.
  task automatic test_steady_tail();
    write_term_count(6'd3);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    for (int i = 0; i < 50; i++) begin
      send_arg(random_arg());
    end
    drain_results();
  endtask

  // Result receiver: random stalls and one long hold-off on request.
  initial begin
    res_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    arctan_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: approximation %0d remainder_bound %0d",
               res_bus.approximation, res_bus.remainder_bound);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_bus.approximation !== want.approximation) begin
          $error("approximation: expected %0d actual %0d",
                 want.approximation, res_bus.approximation);
          mismatch_count++;
        end
        if (res_bus.remainder_bound !== want.remainder_bound) begin
          $error("remainder_bound: expected %0d actual %0d",
                 want.remainder_bound, res_bus.remainder_bound);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    arg_bus.valid   <= 1'b0;
    arg_bus.x_value <= '0;
    term_count_copy = atse_pkg::TC_RESET;
    mismatch_count  = 0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    hold_request    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_count_extremes();
    test_zero_terms();
    test_count_saturation();
    test_random_phases();
    test_backpressure();
    test_steady_tail();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (32 * TERM_LIMIT + 40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/atse_pkg.sv
rtl/atse_in_if.sv
rtl/atse_out_if.sv
rtl/arctan_series_evaluator_core.sv
bench/tb_arctan_series_evaluator_core.sv
